FILE: design/cbs_pkg.sv
package cbs_pkg;

    // Fixed field widths of the stream payload
    localparam int ORDER_W    = 4;
    localparam int POS_W      = 18;
    localparam int IN_TDATA_W = 24;

    // Shifted position is non-negative inside the support, so one bit less
    localparam int XW     = POS_W - 1;
    localparam int LIMB_W = 32;

    // Table limits: orders up to 12, table rows padded to the index range
    localparam int MAX_N_LIM = 12;
    localparam int TAB_N     = 16;
    localparam int BINOM_W   = 10;
    localparam int FACT_W    = 26;

    typedef logic [TAB_N-1:0][TAB_N-1:0][BINOM_W-1:0] binom_tab_t;
    typedef logic [TAB_N-1:0][FACT_W-1:0]             fact_tab_t;

    // Pascal rows C(n,i), zero outside 0 <= i <= n <= MAX_N_LIM
    function automatic binom_tab_t build_binom();
        binom_tab_t tab;
        tab = '0;
        for (int n = 0; n <= MAX_N_LIM; n++) begin
            tab[n][0] = BINOM_W'(1);
            for (int i = 1; i <= n; i++) begin
                tab[n][i] = tab[n-1][i-1] + tab[n-1][i];
            end
        end
        return tab;
    endfunction

    // Entry n holds (n-1)!, entry 0 holds 1
    function automatic fact_tab_t build_fact();
        fact_tab_t tab;
        int        f;
        tab = '0;
        f   = 1;
        tab[0] = FACT_W'(1);
        for (int n = 1; n <= MAX_N_LIM; n++) begin
            if (n > 2) begin
                f = f * (n - 1);
            end
            tab[n] = FACT_W'(f);
        end
        return tab;
    endfunction

    localparam binom_tab_t BINOM_TAB = build_binom();
    localparam fact_tab_t  FACT_TAB  = build_fact();

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TERM,
        ST_MUL,
        ST_ACC,
        ST_SHIFT,
        ST_DIV,
        ST_OUT
    } cbs_state_t;

    typedef struct packed {
        logic load;
        logic next_i;
        logic term_init;
        logic mul_step;
        logic acc;
        logic shift_init;
        logic shift_step;
        logic div_init;
        logic div_step;
        logic out_load;
    } cbs_cmd_t;

    typedef struct packed {
        logic zero_case;
        logic x_neg;
        logic i_last;
        logic mul_done;
        logic shift_done;
        logic div_done;
        logic out_busy;
    } cbs_status_t;

endpackage

FILE: design/cbs_ctrl.sv
module cbs_ctrl
    import cbs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  cbs_status_t status,
    output cbs_cmd_t    cmd
);

    cbs_state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequence one item through terms, scaling and division
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_TERM;
                end
            end
            ST_TERM: begin
                if (status.zero_case) begin
                    state_next = ST_OUT;
                end else if (status.x_neg) begin
                    if (status.i_last) begin
                        cmd.shift_init = 1'b1;
                        state_next     = ST_SHIFT;
                    end else begin
                        cmd.next_i = 1'b1;
                    end
                end else begin
                    cmd.term_init = 1'b1;
                    state_next    = ST_MUL;
                end
            end
            ST_MUL: begin
                if (status.mul_done) begin
                    state_next = ST_ACC;
                end else begin
                    cmd.mul_step = 1'b1;
                end
            end
            ST_ACC: begin
                cmd.acc = 1'b1;
                if (status.i_last) begin
                    cmd.shift_init = 1'b1;
                    state_next     = ST_SHIFT;
                end else begin
                    cmd.next_i = 1'b1;
                    state_next = ST_TERM;
                end
            end
            ST_SHIFT: begin
                if (status.shift_done) begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end else begin
                    cmd.shift_step = 1'b1;
                end
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_OUT: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: design/cbs_datapath.sv
module cbs_datapath
    import cbs_pkg::*;
#(
    parameter int MAX_ORDER     = 10,
    parameter int POS_FRAC_BITS = 12,
    parameter int OUT_FRAC_BITS = 24
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  cbs_cmd_t                   cmd,
    output cbs_status_t                status,
    input  logic [ORDER_W-1:0]         in_order,
    input  logic signed [POS_W-1:0]    in_position,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [OUT_FRAC_BITS:0]     out_value
);

    // Scale shift span and accumulator width that holds the exact sum
    localparam int MAX_SH  = (POS_FRAC_BITS * (MAX_ORDER - 1) > OUT_FRAC_BITS) ?
                             POS_FRAC_BITS * (MAX_ORDER - 1) : OUT_FRAC_BITS;
    localparam int W_MIN   = MAX_SH + 4 * (MAX_ORDER - 1) + 2;
    localparam int NL      = (W_MIN + LIMB_W - 1) / LIMB_W;
    localparam int W       = NL * LIMB_W;
    localparam int JW      = (NL > 1) ? $clog2(NL) : 1;
    localparam int SW      = $clog2(MAX_SH + 1);
    localparam int DW      = $clog2(W + 1);
    localparam int XCW     = ((POS_W > ORDER_W + POS_FRAC_BITS) ?
                              POS_W : ORDER_W + POS_FRAC_BITS) + 1;
    localparam int PW      = LIMB_W + XW;

    logic [ORDER_W-1:0]          n_reg;
    logic signed [POS_W-1:0]     p_reg;
    logic [ORDER_W-1:0]          i_reg;
    logic [ORDER_W-1:0]          e_reg;
    logic [JW-1:0]               j_reg;
    logic [XW-1:0]               x_reg;
    logic [XW-1:0]               carry_reg;
    logic [NL-1:0][LIMB_W-1:0]   term_reg;
    logic [W-1:0]                sum_reg;
    logic [SW-1:0]               sh_cnt_reg;
    logic                        sh_left_reg;
    logic [DW-1:0]               div_cnt_reg;
    logic [FACT_W-1:0]           fct_reg;
    logic [FACT_W-1:0]           rem_reg;
    logic                        out_valid_reg;
    logic [OUT_FRAC_BITS:0]      out_value_reg;

    logic [ORDER_W-1:0]          n_sat;
    logic signed [XCW-1:0]       p_ext;
    logic signed [XCW-1:0]       x_full;
    logic signed [XCW-1:0]       lim_full;
    logic [PW-1:0]               prod;
    logic [SW-1:0]               k_amt;
    logic [SW-1:0]               out_amt;
    logic [FACT_W:0]             rem_shift;
    logic                        rem_ge;

    // Clamp the order to the supported maximum
    assign n_sat = (in_order > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : in_order;

    // Position less the current knot, and the upper end of the support
    assign p_ext    = XCW'(p_reg);
    assign x_full   = p_ext - $signed(XCW'(i_reg) << POS_FRAC_BITS);
    assign lim_full = p_ext - $signed(XCW'(n_reg) << POS_FRAC_BITS);

    // One limb of the running power times the position
    assign prod = PW'(term_reg[j_reg]) * PW'(x_reg) + PW'(carry_reg);

    // Scale: fraction bits of the power against output fraction bits
    assign k_amt   = SW'(POS_FRAC_BITS) * SW'(n_reg - ORDER_W'(1));
    assign out_amt = SW'(OUT_FRAC_BITS);

    // One restoring division step
    assign rem_shift = {rem_reg, sum_reg[W-1]};
    assign rem_ge    = rem_shift >= {1'b0, fct_reg};

    assign status.zero_case  = (n_reg == '0) || p_reg[POS_W-1] || !lim_full[XCW-1];
    assign status.x_neg      = x_full[XCW-1];
    assign status.i_last     = (i_reg == n_reg);
    assign status.mul_done   = (e_reg == n_reg - ORDER_W'(1));
    assign status.shift_done = (sh_cnt_reg == '0);
    assign status.div_done   = (div_cnt_reg == DW'(W));
    assign status.out_busy   = out_valid_reg && !out_ready;

    // Item registers and term loop
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            n_reg   <= n_sat;
            p_reg   <= in_position;
            i_reg   <= '0;
            sum_reg <= '0;
        end
        if (cmd.next_i) begin
            i_reg <= i_reg + ORDER_W'(1);
        end
        if (cmd.term_init) begin
            term_reg  <= W'(BINOM_TAB[n_reg][i_reg]);
            x_reg     <= x_full[XW-1:0];
            carry_reg <= '0;
            e_reg     <= '0;
            j_reg     <= '0;
        end
        if (cmd.mul_step) begin
            term_reg[j_reg] <= prod[LIMB_W-1:0];
            if (j_reg == JW'(NL - 1)) begin
                j_reg     <= '0;
                carry_reg <= '0;
                e_reg     <= e_reg + ORDER_W'(1);
            end else begin
                j_reg     <= j_reg + JW'(1);
                carry_reg <= prod[PW-1:LIMB_W];
            end
        end
        // Alternate the sign of the terms
        if (cmd.acc) begin
            if (i_reg[0]) begin
                sum_reg <= sum_reg - term_reg;
            end else begin
                sum_reg <= sum_reg + term_reg;
            end
        end
        if (cmd.shift_init) begin
            sh_left_reg <= (out_amt >= k_amt);
            sh_cnt_reg  <= (out_amt >= k_amt) ? out_amt - k_amt : k_amt - out_amt;
        end
        if (cmd.shift_step) begin
            sh_cnt_reg <= sh_cnt_reg - SW'(1);
            sum_reg    <= sh_left_reg ? (sum_reg << 1) : (sum_reg >> 1);
        end
        if (cmd.div_init) begin
            fct_reg     <= FACT_TAB[n_reg];
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        if (cmd.div_step) begin
            rem_reg     <= rem_ge ? FACT_W'(rem_shift - {1'b0, fct_reg})
                                  : rem_shift[FACT_W-1:0];
            sum_reg     <= {sum_reg[W-2:0], rem_ge};
            div_cnt_reg <= div_cnt_reg + DW'(1);
        end
    end

    // Output register: hold a result until its transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_value_reg <= sum_reg[OUT_FRAC_BITS:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;

endmodule

FILE: design/cardinal_bspline_eval.sv
// Uniform cardinal B-spline evaluator. Each input transfer carries an order n
// (clamped to MAX_ORDER, order 0 gives 0) and a signed fixed-point position t;
// each one yields exactly one result, the exact B_n(t) floored to unsigned
// fixed point with OUT_FRAC_BITS fraction bits (1.0 is representable). One item
// is worked at a time by a shared 32 x 17 bit limb multiplier, an accumulator,
// a one-bit-per-cycle scaler and a restoring divider. An item outside the
// support skips the terms, scaling and division. The accumulator has L limbs
// (5 at default settings) and W = 32*L bits. Each term with t >= i is built by
// the limb multiply loop and accumulated; then the sum is scaled and divided
// bit by bit. A new item is taken while the previous result still waits on
// the output register.
module cardinal_bspline_eval
    import cbs_pkg::*;
#(
    parameter int MAX_ORDER     = 10,
    parameter int POS_FRAC_BITS = 12,
    parameter int OUT_FRAC_BITS = 24,
    localparam int OUT_TDATA_W  = ((OUT_FRAC_BITS + 1 + 7) / 8) * 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // [3:0] order, [21:4] position, [23:22] zero
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // [OUT_FRAC_BITS:0] value, upper bits zero
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata
);

    cbs_cmd_t               cmd;
    cbs_status_t            status;
    logic [OUT_FRAC_BITS:0] value;

    cbs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cbs_datapath #(
        .MAX_ORDER     (MAX_ORDER),
        .POS_FRAC_BITS (POS_FRAC_BITS),
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .in_order    (s_axis_tdata[ORDER_W-1:0]),
        .in_position (s_axis_tdata[ORDER_W+POS_W-1:ORDER_W]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_value   (value)
    );

    // Pad the result to whole bytes
    assign m_axis_tdata = OUT_TDATA_W'(value);

endmodule
